// ===== design/vsp_pkg.sv =====
// shared types, character codes and parser phase codes for the version string parser
package vsp_pkg;

    localparam int unsigned NUM_PARTS = 4;
    localparam int unsigned PART_W    = 16;
    localparam int unsigned OFS_W     = 8;
    localparam int unsigned CPOS_W    = 9;

    localparam logic [2:0] PH_BEFORE_VERSION = 3'd0;
    localparam logic [2:0] PH_BEFORE_PART    = 3'd1;
    localparam logic [2:0] PH_IN_PART        = 3'd2;
    localparam logic [2:0] PH_AFTER_PARTS    = 3'd3;
    localparam logic [2:0] PH_AFTER_SEP      = 3'd4;
    localparam logic [2:0] PH_COMPLETE       = 3'd5;
    localparam logic [2:0] PH_ERROR          = 3'd6;

    localparam logic [7:0] CH_NONE   = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    localparam logic [CPOS_W-1:0] CPOS_MAX = '1;

    typedef logic [PART_W-1:0] t_part;

    typedef struct packed {
        logic              parse_ok;
        t_part             major;
        t_part             minor;
        t_part             revision;
        t_part             patch;
        logic [OFS_W-1:0]  comment_start;
        logic [OFS_W-1:0]  comment_length;
        logic              too_long;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return (c inside {[CH_TAB:CH_CR], CH_SPACE});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE]});
    endfunction

    function automatic logic [7:0] close_of(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_LPAREN: r = CH_RPAREN;
            CH_LBRACK: r = CH_RBRACK;
            CH_LBRACE: r = CH_RBRACE;
            default:   r = CH_NONE;
        endcase
        return r;
    endfunction

endpackage

// ===== design/vsp_if.sv =====
// request and result channel interfaces of the version string parser
interface vsp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       is_last;

    modport source (output valid, output char_code, output has_char, output is_last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input is_last,
                    output ready);
endinterface

interface vsp_rsp_if;
    logic        valid;
    logic        ready;
    logic        parse_ok;
    logic [15:0] major;
    logic [15:0] minor;
    logic [15:0] revision;
    logic [15:0] patch;
    logic [7:0]  comment_start;
    logic [7:0]  comment_length;
    logic        too_long;

    modport source (output valid, output parse_ok, output major, output minor,
                    output revision, output patch, output comment_start,
                    output comment_length, output too_long, input ready);
    modport sink   (input valid, input parse_ok, input major, input minor,
                    input revision, input patch, input comment_start,
                    input comment_length, input too_long, output ready);
endinterface

// ===== design/version_string_parser_core.sv =====
// version string parser: at most one character per request, one result for the request that carries is_last
// a result is registered when the request that carries is_last is accepted and is valid in the cycle after
// throughput: one request per cycle while the input is not stalled; parser state updates in a single pass per character
// input stalls only while a result waits and the result side is not ready
// reset (synchronous, active low) clears the parser state, the stored version and result valid
module version_string_parser_core
    import vsp_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 256,
    parameter int PART_COUNT   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vsp_req_if.sink     i_req,
    vsp_rsp_if.source   o_rsp
);

    localparam int PosLimitInt = (MAX_TEXT_LEN - 1 < 255) ? (MAX_TEXT_LEN - 1) : 255;
    localparam logic [CPOS_W-1:0] PosLimit  = CPOS_W'(PosLimitInt);
    localparam logic [2:0]        PartLimit = 3'(PART_COUNT);

    logic [2:0]        r_phase, n_phase;
    logic [2:0]        r_part_idx, n_part_idx;
    t_part             r_parts [NUM_PARTS];
    t_part             n_parts [NUM_PARTS];
    t_part             r_stored [NUM_PARTS];
    logic [CPOS_W-1:0] r_cpos, n_cpos;
    logic [7:0]        r_close, n_close;
    logic              r_close_found, n_close_found;
    logic [OFS_W-1:0]  r_tail_lo, n_tail_lo, r_tail_hi, n_tail_hi;
    logic              r_tail_seen, n_tail_seen;
    logic [OFS_W-1:0]  r_inner_lo, n_inner_lo, r_inner_hi, n_inner_hi;
    logic              r_inner_seen, n_inner_seen;
    logic              r_ovf, n_ovf;
    logic              r_out_valid;
    t_result           r_res, n_res;

    logic              accept;
    logic [7:0]        c;
    logic [OFS_W-1:0]  pos;
    logic [3:0]        digit;
    logic [1:0]        widx;
    logic              open_cmt;
    logic              ok;
    logic [2:0]        count;
    logic [OFS_W:0]    span;
    t_part             stored_nx [NUM_PARTS];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign c           = i_req.char_code;
    assign digit       = 4'(c - CH_ZERO);
    assign widx        = r_part_idx[1:0];

    // per-character parser step
    always_comb begin
        n_phase       = r_phase;
        n_part_idx    = r_part_idx;
        n_parts       = r_parts;
        n_cpos        = r_cpos;
        n_close       = r_close;
        n_close_found = r_close_found;
        n_tail_lo     = r_tail_lo;
        n_tail_hi     = r_tail_hi;
        n_tail_seen   = r_tail_seen;
        n_inner_lo    = r_inner_lo;
        n_inner_hi    = r_inner_hi;
        n_inner_seen  = r_inner_seen;
        n_ovf         = r_ovf;
        open_cmt      = 1'b0;
        pos           = r_cpos[OFS_W-1:0];
        if (i_req.has_char) begin
            if (r_cpos > PosLimit) begin
                n_ovf = 1'b1;
                pos   = PosLimit[OFS_W-1:0];
            end
            if (r_cpos != CPOS_MAX) begin
                n_cpos = r_cpos + 1'b1;
            end
            case (r_phase)
                PH_BEFORE_VERSION: begin
                    if (is_digit(c)) begin
                        n_parts[0] = PART_W'(digit);
                        n_phase    = PH_IN_PART;
                    end else if (!is_blank(c)) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_BEFORE_PART: begin
                    if (is_digit(c)) begin
                        if (r_part_idx < PartLimit) begin
                            n_parts[widx] = PART_W'(digit);
                        end
                        n_phase = PH_IN_PART;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_IN_PART: begin
                    if (is_digit(c)) begin
                        if (r_part_idx < PartLimit) begin
                            n_parts[widx] = (r_parts[widx] << 3) + (r_parts[widx] << 1)
                                            + PART_W'(digit);
                        end
                    end else if (c == CH_DOT || is_blank(c)) begin
                        if (r_part_idx < PartLimit) begin
                            n_part_idx = r_part_idx + 1'b1;
                        end
                        n_phase = (c == CH_DOT) ? PH_BEFORE_PART : PH_AFTER_PARTS;
                    end
                end
                PH_AFTER_PARTS: begin
                    if (c == CH_DASH || c == CH_COLON) begin
                        n_phase = PH_AFTER_SEP;
                    end else if (!is_blank(c)) begin
                        open_cmt = 1'b1;
                    end
                end
                PH_AFTER_SEP: begin
                    if (!is_blank(c)) begin
                        open_cmt = 1'b1;
                    end
                end
                PH_COMPLETE: begin
                    if (!is_blank(c)) begin
                        n_tail_hi = pos;
                    end
                    if (r_close != CH_NONE && !r_close_found) begin
                        if (c == r_close) begin
                            n_close_found = 1'b1;
                        end else if (!is_blank(c)) begin
                            if (!r_inner_seen) begin
                                n_inner_lo   = pos;
                                n_inner_seen = 1'b1;
                            end
                            n_inner_hi = pos;
                        end
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
            if (open_cmt) begin
                n_close       = close_of(c);
                n_close_found = 1'b0;
                n_inner_seen  = 1'b0;
                n_tail_lo     = pos;
                n_tail_hi     = pos;
                n_tail_seen   = 1'b1;
                n_phase       = PH_COMPLETE;
            end
        end
    end

    // result of a text that ends with this request
    always_comb begin
        ok = (n_phase == PH_IN_PART) || (n_phase == PH_AFTER_PARTS) ||
             (n_phase == PH_AFTER_SEP) || (n_phase == PH_COMPLETE);
        count = n_part_idx + ((n_phase == PH_IN_PART) ? 3'd1 : 3'd0);
        if (count > PartLimit) begin
            count = PartLimit;
        end
        for (int k = 0; k < NUM_PARTS; k++) begin
            if (ok) begin
                stored_nx[k] = (3'(k) < count) ? n_parts[k] : '0;
            end else begin
                stored_nx[k] = r_stored[k];
            end
        end
        span = '0;
        n_res.comment_start = '0;
        if (ok && n_phase == PH_COMPLETE) begin
            if (n_close != CH_NONE && n_close_found) begin
                if (n_inner_seen) begin
                    n_res.comment_start = n_inner_lo;
                    span = {1'b0, n_inner_hi} - {1'b0, n_inner_lo} + 1'b1;
                end
            end else if (n_tail_seen) begin
                n_res.comment_start = n_tail_lo;
                span = {1'b0, n_tail_hi} - {1'b0, n_tail_lo} + 1'b1;
            end
        end
        n_res.comment_length = span[OFS_W] ? '1 : span[OFS_W-1:0];
        n_res.parse_ok = ok;
        n_res.major    = stored_nx[0];
        n_res.minor    = stored_nx[1];
        n_res.revision = stored_nx[2];
        n_res.patch    = stored_nx[3];
        n_res.too_long = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_BEFORE_VERSION;
            r_part_idx    <= '0;
            r_cpos        <= '0;
            r_close       <= CH_NONE;
            r_close_found <= 1'b0;
            r_tail_lo     <= '0;
            r_tail_hi     <= '0;
            r_tail_seen   <= 1'b0;
            r_inner_lo    <= '0;
            r_inner_hi    <= '0;
            r_inner_seen  <= 1'b0;
            r_ovf         <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < NUM_PARTS; k++) begin
                r_stored[k] <= '0;
            end
        end else begin
            if (accept && i_req.is_last) begin
                r_phase       <= PH_BEFORE_VERSION;
                r_part_idx    <= '0;
                r_cpos        <= '0;
                r_close       <= CH_NONE;
                r_close_found <= 1'b0;
                r_tail_lo     <= '0;
                r_tail_hi     <= '0;
                r_tail_seen   <= 1'b0;
                r_inner_lo    <= '0;
                r_inner_hi    <= '0;
                r_inner_seen  <= 1'b0;
                r_ovf         <= 1'b0;
                r_stored      <= stored_nx;
            end else if (accept) begin
                r_phase       <= n_phase;
                r_part_idx    <= n_part_idx;
                r_cpos        <= n_cpos;
                r_close       <= n_close;
                r_close_found <= n_close_found;
                r_tail_lo     <= n_tail_lo;
                r_tail_hi     <= n_tail_hi;
                r_tail_seen   <= n_tail_seen;
                r_inner_lo    <= n_inner_lo;
                r_inner_hi    <= n_inner_hi;
                r_inner_seen  <= n_inner_seen;
                r_ovf         <= n_ovf;
            end
            if (accept && i_req.is_last) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working parts and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_parts <= n_parts;
        end
        if (accept && i_req.is_last) begin
            r_res <= n_res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.parse_ok       = r_res.parse_ok;
    assign o_rsp.major          = r_res.major;
    assign o_rsp.minor          = r_res.minor;
    assign o_rsp.revision       = r_res.revision;
    assign o_rsp.patch          = r_res.patch;
    assign o_rsp.comment_start  = r_res.comment_start;
    assign o_rsp.comment_length = r_res.comment_length;
    assign o_rsp.too_long       = r_res.too_long;

endmodule

// ===== bench/tb_version_string_parser_core.sv =====
// testbench for the version string parser core: streams version texts and checks each result
module tb_version_string_parser_core
    import vsp_pkg::*;
();

    localparam int TEXT_LEN     = 256;
    localparam int POS_LIMIT    = (TEXT_LEN - 1 < 255) ? TEXT_LEN - 1 : 255;
    localparam int TOTAL_ITEMS  = 1350;
    localparam int LONG_AT      = 700;
    localparam int MAX_WAIT     = 10;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_EVERY   = 300;

    typedef struct {
        logic [7:0] code;
        logic       has;
        logic       last;
        bit         hold;
    } t_char_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vsp_req_if req_ch ();
    vsp_rsp_if rsp_ch ();

    version_string_parser_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_char_req  char_queue[$];
    t_result    expected_versions[$];
    logic [7:0] text_buf[$];
    t_char_req  cur_req;
    int queued_total = 0;
    int accepted_total = 0;
    int result_total = 0;
    int error_count = 0;
    int random_items = 0;
    int cycle_count = 0;
    int drv_wait = 0;
    int mon_wait = 0;
    bit drv_calm = 1'b0;
    bit mon_calm = 1'b0;

    // parser model state
    logic [2:0] vp_phase;
    int         vp_part;
    t_part      vp_work [NUM_PARTS];
    t_part      vp_store [NUM_PARTS];
    int         vp_pos;
    logic [7:0] vp_close;
    bit         vp_closed, vp_tail_on, vp_inner_on, vp_clamped;
    logic [7:0] vp_tail_lo, vp_tail_hi, vp_inner_lo, vp_inner_hi;

    always #5 i_clk = ~i_clk;

    function automatic bit blank_byte(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit digit_byte(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic restart_text();
        vp_phase = PH_BEFORE_VERSION;
        vp_part = 0;
        foreach (vp_work[k]) vp_work[k] = '0;
        vp_pos = 0;
        vp_close = CH_NONE;
        vp_closed = 1'b0;
        vp_tail_lo = '0;
        vp_tail_hi = '0;
        vp_tail_on = 1'b0;
        vp_inner_lo = '0;
        vp_inner_hi = '0;
        vp_inner_on = 1'b0;
        vp_clamped = 1'b0;
    endtask

    task automatic reset_version_model();
        foreach (vp_store[k]) vp_store[k] = '0;
        restart_text();
    endtask

    task automatic begin_comment(input logic [7:0] c, input logic [7:0] pos);
        case (c)
            CH_LPAREN: vp_close = CH_RPAREN;
            CH_LBRACK: vp_close = CH_RBRACK;
            CH_LBRACE: vp_close = CH_RBRACE;
            default:   vp_close = CH_NONE;
        endcase
        vp_closed = 1'b0;
        vp_inner_on = 1'b0;
        vp_tail_lo = pos;
        vp_tail_hi = pos;
        vp_tail_on = 1'b1;
        vp_phase = PH_COMPLETE;
    endtask

    task automatic absorb_char(input logic [7:0] c, input logic [7:0] pos);
        case (vp_phase)
            PH_BEFORE_VERSION: begin
                if (digit_byte(c)) begin
                    vp_work[0] = PART_W'(c - CH_ZERO);
                    vp_phase = PH_IN_PART;
                end else if (!blank_byte(c)) begin
                    vp_phase = PH_ERROR;
                end
            end
            PH_BEFORE_PART: begin
                if (digit_byte(c)) begin
                    if (vp_part < NUM_PARTS) vp_work[vp_part] = PART_W'(c - CH_ZERO);
                    vp_phase = PH_IN_PART;
                end else begin
                    vp_phase = PH_ERROR;
                end
            end
            PH_IN_PART: begin
                if (digit_byte(c)) begin
                    if (vp_part < NUM_PARTS)
                        vp_work[vp_part] = vp_work[vp_part] * 16'd10 + PART_W'(c - CH_ZERO);
                end else if (c == CH_DOT || blank_byte(c)) begin
                    if (vp_part < NUM_PARTS) vp_part++;
                    vp_phase = (c == CH_DOT) ? PH_BEFORE_PART : PH_AFTER_PARTS;
                end
            end
            PH_AFTER_PARTS: begin
                if (c == CH_DASH || c == CH_COLON) vp_phase = PH_AFTER_SEP;
                else if (!blank_byte(c)) begin_comment(c, pos);
            end
            PH_AFTER_SEP: begin
                if (!blank_byte(c)) begin_comment(c, pos);
            end
            PH_COMPLETE: begin
                if (!blank_byte(c)) vp_tail_hi = pos;
                if (vp_close != CH_NONE && !vp_closed) begin
                    if (c == vp_close) begin
                        vp_closed = 1'b1;
                    end else if (!blank_byte(c)) begin
                        if (!vp_inner_on) begin
                            vp_inner_lo = pos;
                            vp_inner_on = 1'b1;
                        end
                        vp_inner_hi = pos;
                    end
                end
            end
            default: vp_phase = PH_ERROR;
        endcase
    endtask

    task automatic step_version_parser(input t_char_req it);
        t_result    r;
        logic [7:0] pos;
        int         cnt, cstart, clen;
        bit         good;
        if (it.has) begin
            if (vp_pos > POS_LIMIT) begin
                vp_clamped = 1'b1;
                pos = 8'(POS_LIMIT);
            end else begin
                pos = 8'(vp_pos);
            end
            absorb_char(it.code, pos);
            if (vp_pos < CPOS_MAX) vp_pos++;
        end
        if (it.last) begin
            good = vp_phase == PH_IN_PART || vp_phase == PH_AFTER_PARTS ||
                   vp_phase == PH_AFTER_SEP || vp_phase == PH_COMPLETE;
            cstart = 0;
            clen = 0;
            if (good) begin
                cnt = vp_part + ((vp_phase == PH_IN_PART) ? 1 : 0);
                if (cnt > NUM_PARTS) cnt = NUM_PARTS;
                for (int k = 0; k < NUM_PARTS; k++) vp_store[k] = (k < cnt) ? vp_work[k] : '0;
                if (vp_phase == PH_COMPLETE) begin
                    if (vp_close != CH_NONE && vp_closed) begin
                        if (vp_inner_on) begin
                            cstart = int'(vp_inner_lo);
                            clen = int'(vp_inner_hi) - int'(vp_inner_lo) + 1;
                        end
                    end else if (vp_tail_on) begin
                        cstart = int'(vp_tail_lo);
                        clen = int'(vp_tail_hi) - int'(vp_tail_lo) + 1;
                    end
                    if (clen > 255) clen = 255;
                end
            end
            r.parse_ok = good;
            r.major = vp_store[0];
            r.minor = vp_store[1];
            r.revision = vp_store[2];
            r.patch = vp_store[3];
            r.comment_start = 8'(cstart);
            r.comment_length = 8'(clen);
            r.too_long = vp_clamped;
            expected_versions.insert(expected_versions.size(), r);
            restart_text();
        end
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 50) $display("error: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is %0h, expected %0h",
                                   result_total, name, got, want));
    endtask

    task automatic check_version_result();
        t_result want;
        result_total++;
        if (expected_versions.size() == 0) begin
            report_error($sformatf("result %0d arrived with none expected", result_total));
        end else begin
            want = expected_versions.pop_front();
            compare_field("parse_ok", 16'(rsp_ch.parse_ok), 16'(want.parse_ok));
            compare_field("major", rsp_ch.major, want.major);
            compare_field("minor", rsp_ch.minor, want.minor);
            compare_field("revision", rsp_ch.revision, want.revision);
            compare_field("patch", rsp_ch.patch, want.patch);
            compare_field("comment_start", 16'(rsp_ch.comment_start),
                          16'(want.comment_start));
            compare_field("comment_length", 16'(rsp_ch.comment_length),
                          16'(want.comment_length));
            compare_field("too_long", 16'(rsp_ch.too_long), 16'(want.too_long));
        end
    endtask

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 29) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [7:0] any_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (digit_byte(c) || blank_byte(c) || c == CH_DOT);
        return c;
    endfunction

    function automatic logic [7:0] comment_byte();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = any_blank();
            1:       c = 8'($urandom_range(0, 255));
            default: c = 8'($urandom_range(33, 126));
        endcase
        return c;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    task automatic put_str(input string s);
        for (int k = 0; k < s.len(); k++) put_byte(s[k]);
    endtask

    task automatic push_req(input logic [7:0] code, input logic has, input logic last,
                            input bit hold, input bit counted);
        t_char_req it;
        it.code = code;
        it.has = has;
        it.last = last;
        it.hold = hold;
        char_queue.insert(char_queue.size(), it);
        queued_total++;
        if (counted && (has || last)) random_items++;
    endtask

    // one text as requests, with stray empty steps and sometimes an empty closing step
    task automatic flush_text(input bit hold, input bit counted);
        bit first;
        bit tail_empty;
        first = hold;
        tail_empty = ($urandom_range(0, 7) == 0);
        if (text_buf.size() == 0) begin
            push_req(8'($urandom), 1'b0, 1'b1, hold, counted);
        end else begin
            for (int k = 0; k < text_buf.size(); k++) begin
                if ($urandom_range(0, 24) == 0) begin
                    push_req(8'($urandom), 1'b0, 1'b0, first, counted);
                    first = 1'b0;
                end
                push_req(text_buf[k], 1'b1, (k == text_buf.size() - 1) && !tail_empty,
                         first, counted);
                first = 1'b0;
            end
            if (tail_empty) push_req(8'($urandom), 1'b0, 1'b1, 1'b0, counted);
        end
        text_buf.delete();
    endtask

    task automatic add_comment(input int body_len);
        logic [7:0] closer;
        case ($urandom_range(0, 4))
            0: begin
                put_byte(CH_LPAREN);
                closer = CH_RPAREN;
            end
            1: begin
                put_byte(CH_LBRACK);
                closer = CH_RBRACK;
            end
            2: begin
                put_byte(CH_LBRACE);
                closer = CH_RBRACE;
            end
            default: begin
                put_byte(8'($urandom_range(33, 126)));
                closer = CH_NONE;
            end
        endcase
        repeat (body_len) put_byte(comment_byte());
        if (closer != CH_NONE && $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
                0:       put_byte(CH_RPAREN);
                1:       put_byte(CH_RBRACK);
                2:       put_byte(CH_RBRACE);
                default: put_byte(closer);
            endcase
            repeat ($urandom_range(0, 3)) put_byte(comment_byte());
        end
    endtask

    task automatic build_version_text();
        int parts, digits, ending;
        repeat ($urandom_range(0, 2)) put_byte(any_blank());
        parts = $urandom_range(1, 6);
        for (int p = 0; p < parts; p++) begin
            digits = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
            for (int k = 0; k < digits; k++) begin
                put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 15) == 0) put_byte(junk_byte());
            end
            if (p < parts - 1) put_byte(CH_DOT);
        end
        ending = $urandom_range(0, 9);
        if (ending == 1) begin
            put_byte(CH_DOT);
        end else if (ending > 1) begin
            repeat ($urandom_range(1, 2)) put_byte(any_blank());
            case ($urandom_range(0, 2))
                0:       put_byte(CH_DASH);
                1:       put_byte(CH_COLON);
                default: ;
            endcase
            repeat ($urandom_range(0, 2)) put_byte(any_blank());
            if ($urandom_range(0, 3) != 0) add_comment($urandom_range(0, 8));
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            drv_wait = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                step_version_parser(cur_req);
                accepted_total++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (drv_wait > 0) begin
                    drv_wait--;
                    req_ch.valid <= 1'b0;
                end else if (char_queue.size() > 0 &&
                             !(char_queue[0].hold && expected_versions.size() > 0)) begin
                    cur_req = char_queue.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.char_code <= cur_req.code;
                    req_ch.has_char <= cur_req.has;
                    req_ch.is_last <= cur_req.last;
                    drv_wait = draw_wait(drv_calm);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            mon_wait = 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            check_version_result();
            mon_wait = draw_wait(mon_calm);
            rsp_ch.ready <= (mon_wait == 0);
        end else if (mon_wait > 0) begin
            mon_wait--;
            rsp_ch.ready <= (mon_wait == 0);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        int  kind;
        int  next_hold;
        bit  hold;
        bit  long_done;
        req_ch.valid = 1'b0;
        req_ch.char_code = '0;
        req_ch.has_char = 1'b0;
        req_ch.is_last = 1'b0;
        rsp_ch.ready = 1'b0;
        reset_version_model();

        // directed texts
        flush_text(1'b0, 1'b0);
        put_str("1.2.3.4");
        flush_text(1'b0, 1'b0);
        for (int b = CH_TAB; b <= CH_CR; b++) put_byte(8'(b));
        put_str(" 65535.65536.99999.0");
        flush_text(1'b0, 1'b0);
        put_str("1.2.3.4.5.6");
        flush_text(1'b0, 1'b0);
        put_str("7.x");
        flush_text(1'b1, 1'b0);
        put_str("x1");
        flush_text(1'b0, 1'b0);
        put_str("3a4b.5");
        flush_text(1'b0, 1'b0);
        put_str("1.");
        flush_text(1'b0, 1'b0);
        put_str("   ");
        flush_text(1'b0, 1'b0);
        put_str("5-");
        flush_text(1'b0, 1'b0);
        put_str("6 : hello world  ");
        flush_text(1'b0, 1'b0);
        put_str("2 -(inner) tail");
        flush_text(1'b0, 1'b0);
        put_str("2 [ x ]");
        flush_text(1'b0, 1'b0);
        put_str("2 {abc");
        flush_text(1'b0, 1'b0);
        put_str("2 (  )");
        flush_text(1'b0, 1'b0);
        put_str("1 (a)b)");
        flush_text(1'b0, 1'b0);
        put_str("4:( ]");
        flush_text(1'b0, 1'b0);
        put_str("8 z(y]");
        flush_text(1'b0, 1'b0);
        put_str("9 ");
        put_byte(8'hff);
        put_byte(8'h00);
        put_byte(8'hff);
        flush_text(1'b0, 1'b0);
        put_str("0.0.0.0 -");
        flush_text(1'b0, 1'b0);
        put_str("12.34 ");
        add_comment(300);
        flush_text(1'b0, 1'b0);

        // random texts, mostly well formed
        next_hold = 0;
        long_done = 1'b0;
        while (queued_total < TOTAL_ITEMS) begin
            hold = 1'b0;
            if (random_items >= next_hold) begin
                hold = 1'b1;
                next_hold += HOLD_EVERY;
            end
            if (!long_done && queued_total >= LONG_AT) begin
                put_str("65535.1.2 ");
                add_comment($urandom_range(515, 530));
                flush_text(1'b0, 1'b0);
                long_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind >= 5 && kind < 20) begin
                repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
            end else if (kind >= 20) begin
                build_version_text();
                if (kind >= 90)
                    text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end
            flush_text(hold, 1'b1);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (accepted_total < queued_total) @(posedge i_clk);
        while (expected_versions.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
